// ----- src/hsc_pkg.sv -----
// ----------------------------------------------------------------------------
// hsc_pkg: shared types, constants and helpers for the Hamming SEC codec
// Transaction payloads, function codes and elaboration-time position helpers.
// ----------------------------------------------------------------------------
package hsc_pkg;

  localparam int DATA_BITS_DEFAULT = 8;
  localparam int IN_W              = 12;
  localparam int OUT_W             = 12;
  localparam int SYN_W             = 4;
  localparam int MAX_CW_W          = 63;

  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  typedef struct packed {
    logic            func;
    logic [IN_W-1:0] in_bits;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] out_bits;
    logic [SYN_W-1:0] syndrome;
    logic             corrected;
    logic             syndrome_out_of_range;
  } out_t;

  // Per-stage control that travels with the codeword
  typedef struct packed {
    logic valid;
    logic func;
  } ctl_t;

  // Smallest r with 2^r >= r + d + 1, capped at 6
  function automatic int parity_count(int d);
    int r;
    r = 1;
    while (r < 6 && (1 << r) < r + d + 1) r++;
    return r;
  endfunction

  function automatic bit is_pow2(int p);
    return (p != 0) && ((p & (p - 1)) == 0);
  endfunction

  // 1-based codeword position of data bit j
  function automatic int data_pos(int j);
    int cnt;
    int res;
    cnt = 0;
    res = 0;
    for (int p = 1; p <= MAX_CW_W; p++) begin
      if (!is_pow2(p)) begin
        if (cnt == j && res == 0) res = p;
        cnt++;
      end
    end
    return res;
  endfunction

  // Positions covered by parity group i (bit p-1 set when bit i of p is set)
  function automatic logic [MAX_CW_W-1:0] group_mask(int i);
    logic [MAX_CW_W-1:0] m;
    m = '0;
    for (int p = 1; p <= MAX_CW_W; p++) begin
      m[p-1] = ((p >> i) & 1) != 0;
    end
    return m;
  endfunction

endpackage

// ----- src/hamming_sec_codec.sv -----
// ----------------------------------------------------------------------------
// hamming_sec_codec: single-error-correcting Hamming encoder / decoder
// Even parity, parity bits at power-of-two positions, bit 0 is position 1.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken on req_i at each rising edge where start is high
//   and busy is low. req_i.func selects encode (data in the low bits) or
//   decode (received codeword). busy stays low: the block takes one
//   transaction every cycle, back to back.
//   Each result shows on rsp_o for one cycle with done_o high. The three
//   register stages are input scatter, syndrome XOR trees, and
//   correct/extract; results leave in input order. The receiver cannot
//   hold results off, and none is needed: each stage moves every cycle.
//   Decode flips the bit the syndrome names; a syndrome past the codeword
//   length leaves the word as received and raises syndrome_out_of_range.
//   Reset (rst_ni low, asynchronous) clears all valid bits; transactions in
//   flight are dropped.
// ----------------------------------------------------------------------------
module hamming_sec_codec #(
  parameter int DATA_BITS = hsc_pkg::DATA_BITS_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  hsc_pkg::in_t  req_i,
  output logic          done_o,
  output hsc_pkg::out_t rsp_o
);

  localparam int R = hsc_pkg::parity_count(DATA_BITS);
  localparam int N = R + DATA_BITS;

  hsc_pkg::ctl_t ctl1;
  hsc_pkg::ctl_t ctl2;
  logic [N-1:0]  cw1;
  logic [N-1:0]  cw2;
  logic [R-1:0]  syn2;

  assign busy = 1'b0;

  hsc_prep #(.DATA_BITS(DATA_BITS)) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .req_i   (req_i),
    .ctl_o   (ctl1),
    .cw_o    (cw1)
  );

  hsc_syn #(.DATA_BITS(DATA_BITS)) u_syn (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl1),
    .cw_i   (cw1),
    .ctl_o  (ctl2),
    .cw_o   (cw2),
    .syn_o  (syn2)
  );

  hsc_fix #(.DATA_BITS(DATA_BITS)) u_fix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl2),
    .cw_i   (cw2),
    .syn_i  (syn2),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

// ----- src/hsc_prep.sv -----
// ----------------------------------------------------------------------------
// hsc_prep: input stage
// Scatters data bits into a zero-parity codeword (encode) or masks the
// received codeword to its length (decode), then registers it.
// ----------------------------------------------------------------------------
module hsc_prep #(
  parameter int DATA_BITS = hsc_pkg::DATA_BITS_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  hsc_pkg::in_t                 req_i,
  output hsc_pkg::ctl_t                ctl_o,
  output logic [hsc_pkg::parity_count(DATA_BITS)+DATA_BITS-1:0] cw_o
);

  localparam int R = hsc_pkg::parity_count(DATA_BITS);
  localparam int N = R + DATA_BITS;

  logic [N-1:0]  enc_w;
  logic [N-1:0]  dec_w;
  hsc_pkg::ctl_t ctl_q;
  logic [N-1:0]  cw_q;

  for (genvar j = 0; j < DATA_BITS; j++) begin : g_enc
    localparam int P = hsc_pkg::data_pos(j);
    if (j < hsc_pkg::IN_W) begin : g_in
      assign enc_w[P-1] = req_i.in_bits[j];
    end else begin : g_zero
      assign enc_w[P-1] = 1'b0;
    end
  end

  for (genvar i = 0; i < R; i++) begin : g_par
    assign enc_w[(1 << i) - 1] = 1'b0;
  end

  for (genvar p = 0; p < N; p++) begin : g_dec
    if (p < hsc_pkg::IN_W) begin : g_in
      assign dec_w[p] = req_i.in_bits[p];
    end else begin : g_zero
      assign dec_w[p] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q.valid <= valid_i;
      ctl_q.func  <= req_i.func;
    end
  end

  always_ff @(posedge clk_i) begin
    cw_q <= (req_i.func == hsc_pkg::FUNC_DECODE) ? dec_w : enc_w;
  end

  assign ctl_o = ctl_q;
  assign cw_o  = cw_q;

endmodule

// ----- src/hsc_syn.sv -----
// ----------------------------------------------------------------------------
// hsc_syn: syndrome stage
// One XOR tree per parity group over the registered codeword.
// ----------------------------------------------------------------------------
module hsc_syn #(
  parameter int DATA_BITS = hsc_pkg::DATA_BITS_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hsc_pkg::ctl_t                ctl_i,
  input  logic [hsc_pkg::parity_count(DATA_BITS)+DATA_BITS-1:0] cw_i,
  output hsc_pkg::ctl_t                ctl_o,
  output logic [hsc_pkg::parity_count(DATA_BITS)+DATA_BITS-1:0] cw_o,
  output logic [hsc_pkg::parity_count(DATA_BITS)-1:0]           syn_o
);

  localparam int R = hsc_pkg::parity_count(DATA_BITS);
  localparam int N = R + DATA_BITS;

  logic [R-1:0]  syn_d;
  logic [R-1:0]  syn_q;
  logic [N-1:0]  cw_q;
  hsc_pkg::ctl_t ctl_q;

  for (genvar i = 0; i < R; i++) begin : g_grp
    localparam logic [hsc_pkg::MAX_CW_W-1:0] M = hsc_pkg::group_mask(i);
    assign syn_d[i] = ^(cw_i & M[N-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cw_q  <= cw_i;
    syn_q <= syn_d;
  end

  assign ctl_o = ctl_q;
  assign cw_o  = cw_q;
  assign syn_o = syn_q;

endmodule

// ----- src/hsc_fix.sv -----
// ----------------------------------------------------------------------------
// hsc_fix: correction and output stage
// Inserts parity (encode) or flips the named bit and extracts data (decode),
// then registers the result transaction.
// ----------------------------------------------------------------------------
module hsc_fix #(
  parameter int DATA_BITS = hsc_pkg::DATA_BITS_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hsc_pkg::ctl_t                ctl_i,
  input  logic [hsc_pkg::parity_count(DATA_BITS)+DATA_BITS-1:0] cw_i,
  input  logic [hsc_pkg::parity_count(DATA_BITS)-1:0]           syn_i,
  output logic                         done_o,
  output hsc_pkg::out_t                rsp_o
);

  localparam int R = hsc_pkg::parity_count(DATA_BITS);
  localparam int N = R + DATA_BITS;
  localparam logic [R-1:0] N_CODE = R'(N);

  logic [N-1:0]               par_w;
  logic [N-1:0]               enc_cw;
  logic [N-1:0]               flip_w;
  logic [N-1:0]               fix_cw;
  logic [hsc_pkg::OUT_W-1:0]  enc_out;
  logic [hsc_pkg::OUT_W-1:0]  dec_out;
  logic [hsc_pkg::SYN_W-1:0]  syn_ext;
  logic                       syn_nz;
  logic                       oor;
  hsc_pkg::out_t              rsp_d;
  hsc_pkg::out_t              rsp_q;
  logic                       done_q;

  // Parity bits sit at zero after the input stage, so XOR sets them
  for (genvar p = 1; p <= N; p++) begin : g_pos
    localparam logic [R-1:0] P_CODE = R'(p);
    if (hsc_pkg::is_pow2(p)) begin : g_par
      assign par_w[p-1] = syn_i[$clog2(p)];
    end else begin : g_dat
      assign par_w[p-1] = 1'b0;
    end
    assign flip_w[p-1] = (syn_i == P_CODE);
  end

  assign enc_cw = cw_i ^ par_w;
  // No position matches a zero or out-of-range syndrome
  assign fix_cw = cw_i ^ flip_w;
  assign syn_nz = |syn_i;
  assign oor    = syn_i > N_CODE;

  for (genvar k = 0; k < hsc_pkg::OUT_W; k++) begin : g_out
    if (k < N) begin : g_enc
      assign enc_out[k] = enc_cw[k];
    end else begin : g_enc_zero
      assign enc_out[k] = 1'b0;
    end
    if (k < DATA_BITS) begin : g_dec
      assign dec_out[k] = fix_cw[hsc_pkg::data_pos(k)-1];
    end else begin : g_dec_zero
      assign dec_out[k] = 1'b0;
    end
  end

  for (genvar k = 0; k < hsc_pkg::SYN_W; k++) begin : g_syn
    if (k < R) begin : g_bit
      assign syn_ext[k] = syn_i[k];
    end else begin : g_zero
      assign syn_ext[k] = 1'b0;
    end
  end

  always_comb begin
    if (ctl_i.func == hsc_pkg::FUNC_DECODE) begin
      rsp_d.out_bits              = dec_out;
      rsp_d.syndrome              = syn_ext;
      rsp_d.corrected             = syn_nz && !oor;
      rsp_d.syndrome_out_of_range = oor;
    end else begin
      rsp_d.out_bits              = enc_out;
      rsp_d.syndrome              = '0;
      rsp_d.corrected             = 1'b0;
      rsp_d.syndrome_out_of_range = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ----- src/hsc_checker.sv -----
// ----------------------------------------------------------------------------
// hsc_checker: port-level checks for the Hamming SEC codec
// Latency, no results without an accept, and encode/decode status consistency.
// ----------------------------------------------------------------------------
module hsc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input hsc_pkg::in_t  req_i,
  input logic          done_o,
  input hsc_pkg::out_t rsp_o
);

  // Every accepted transaction yields a result on done_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##2 done_o)
    else $error("result missing three cycles after accept");

  // No result without a matching accept
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 3))
    else $error("result without accepted transaction");

  // Encode results carry clean status
  a_enc_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(req_i.func, 3) == hsc_pkg::FUNC_ENCODE) |->
      (rsp_o.syndrome == '0 && !rsp_o.corrected && !rsp_o.syndrome_out_of_range))
    else $error("encode result with nonzero status");

  // A decode never both corrects and flags out of range
  a_dec_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(req_i.func, 3) == hsc_pkg::FUNC_DECODE) |->
      !(rsp_o.corrected && rsp_o.syndrome_out_of_range))
    else $error("corrected and out-of-range both set");

endmodule

bind hamming_sec_codec hsc_checker u_hsc_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

// ----- dv/hamming_sec_codec_tb.sv -----
// ----------------------------------------------------------------------------
// hamming_sec_codec_tb: self-checking bench for the Hamming SEC codec
// Drives encode and decode transactions with random gaps, predicts every
// response and compares it field by field in arrival order.
// ----------------------------------------------------------------------------
module hamming_sec_codec_tb;

  localparam int DBITS      = hsc_pkg::DATA_BITS_DEFAULT;
  localparam int IN_W       = hsc_pkg::IN_W;
  localparam int OUT_W      = hsc_pkg::OUT_W;
  localparam int SYN_W      = hsc_pkg::SYN_W;
  localparam int N_RANDOM   = 650;
  localparam int CYCLE_CAP  = 200000;
  localparam int FLUSH_CYC  = 10;

  typedef struct {
    hsc_pkg::in_t req;
    bit           wait_drain;  // hold until every outstanding response is back
    bit           may_idle;
  } codec_op_t;

  logic          clk_i  = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start  = 1'b0;
  hsc_pkg::in_t  req_i  = '0;
  logic          busy;
  logic          done_o;
  hsc_pkg::out_t rsp_o;

  codec_op_t     op_q[$];
  hsc_pkg::out_t rsp_exp_q[$];
  int            sent_cnt     = 0;
  int            results_seen = 0;
  int            gap_left     = 0;
  int            cycle_cnt    = 0;
  bit            failed       = 1'b0;

  hamming_sec_codec dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always #4 clk_i = ~clk_i;

  // Check bit count: smallest r with 2^r >= r + d + 1
  function automatic int check_count(int d);
    int r;
    r = 1;
    while ((1 << r) < r + d + 1) r++;
    return r;
  endfunction

  localparam int N_CHECKS = check_count(DBITS);
  localparam int CW_LEN   = N_CHECKS + DBITS;

  function automatic bit is_check_pos(int p);
    return (p & (p - 1)) == 0;
  endfunction

  // Syndrome is the XOR of the positions of all set bits
  function automatic logic [SYN_W-1:0] parity_checks(logic [OUT_W-1:0] cw);
    logic [SYN_W-1:0] s;
    s = '0;
    for (int p = 1; p <= CW_LEN; p++) begin
      if (cw[p-1]) s ^= SYN_W'(p);
    end
    return s;
  endfunction

  function automatic logic [OUT_W-1:0] hamming_encode(logic [IN_W-1:0] d);
    logic [OUT_W-1:0] cw;
    logic [SYN_W-1:0] s;
    int               j;
    cw = '0;
    j  = 0;
    for (int p = 1; p <= CW_LEN; p++) begin
      if (!is_check_pos(p)) begin
        cw[p-1] = d[j];
        j++;
      end
    end
    s = parity_checks(cw);
    for (int i = 0; i < N_CHECKS; i++) begin
      if (s[i]) cw[(1 << i) - 1] = ~cw[(1 << i) - 1];
    end
    return cw;
  endfunction

  function automatic hsc_pkg::out_t hamming_expect(hsc_pkg::in_t req);
    hsc_pkg::out_t    r;
    logic [OUT_W-1:0] cw;
    int               j;
    r = '0;
    if (req.func == hsc_pkg::FUNC_ENCODE) begin
      r.out_bits = hamming_encode(req.in_bits);
    end else begin
      cw = req.in_bits;
      r.syndrome = parity_checks(cw);
      if (r.syndrome != '0) begin
        if (int'(r.syndrome) <= CW_LEN) begin
          cw[r.syndrome - 1] = ~cw[r.syndrome - 1];
          r.corrected = 1'b1;
        end else begin
          r.syndrome_out_of_range = 1'b1;
        end
      end
      j = 0;
      for (int p = 1; p <= CW_LEN; p++) begin
        if (!is_check_pos(p)) begin
          r.out_bits[j] = cw[p-1];
          j++;
        end
      end
    end
    return r;
  endfunction

  function automatic void queue_op(logic fn, logic [IN_W-1:0] bits, bit drain,
                                   bit idle);
    codec_op_t op;
    op.req.func    = fn;
    op.req.in_bits = bits;
    op.wait_drain  = drain;
    op.may_idle    = idle;
    op_q.push_back(op);
  endfunction

  // Driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
    end else begin
      if (start && !busy) sent_cnt++;
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (op_q.size() != 0 &&
                     !(op_q[0].wait_drain && sent_cnt != results_seen)) begin
          req_i <= op_q[0].req;
          start <= 1'b1;
          if (op_q[0].may_idle && $urandom_range(0, 3) == 0)
            gap_left = $urandom_range(1, 14);
          void'(op_q.pop_front());
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: record accepted transactions, check responses in order
  always @(posedge clk_i) begin
    hsc_pkg::out_t e;
    if (rst_ni) begin
      if (start && !busy) rsp_exp_q.push_back(hamming_expect(req_i));
      if (done_o) begin
        results_seen <= results_seen + 1;
        if (rsp_exp_q.size() == 0) begin
          $error("unexpected response: out_bits %h", rsp_o.out_bits);
          failed = 1'b1;
        end else begin
          e = rsp_exp_q.pop_front();
          if (rsp_o.out_bits !== e.out_bits) begin
            $error("out_bits: expected %h, got %h", e.out_bits, rsp_o.out_bits);
            failed = 1'b1;
          end
          if (rsp_o.syndrome !== e.syndrome) begin
            $error("syndrome: expected %h, got %h", e.syndrome, rsp_o.syndrome);
            failed = 1'b1;
          end
          if (rsp_o.corrected !== e.corrected) begin
            $error("corrected: expected %b, got %b", e.corrected, rsp_o.corrected);
            failed = 1'b1;
          end
          if (rsp_o.syndrome_out_of_range !== e.syndrome_out_of_range) begin
            $error("syndrome_out_of_range: expected %b, got %b",
                   e.syndrome_out_of_range, rsp_o.syndrome_out_of_range);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("[hamming_sec_codec] ERROR");
      $finish;
    end
  end

  initial begin
    logic [OUT_W-1:0] cw;
    int               kind;
    int               p0;
    bit               idle;
    cw = hamming_encode(12'h0A5);

    // Encode extremes; upper input bits must be ignored
    queue_op(hsc_pkg::FUNC_ENCODE, 12'h000, 1'b0, 1'b0);
    queue_op(hsc_pkg::FUNC_ENCODE, 12'h0FF, 1'b0, 1'b0);
    queue_op(hsc_pkg::FUNC_ENCODE, 12'hFFF, 1'b0, 1'b0);
    queue_op(hsc_pkg::FUNC_ENCODE, 12'h001, 1'b0, 1'b0);
    queue_op(hsc_pkg::FUNC_ENCODE, 12'h080, 1'b0, 1'b0);
    queue_op(hsc_pkg::FUNC_ENCODE, 12'h055, 1'b0, 1'b0);
    queue_op(hsc_pkg::FUNC_ENCODE, 12'h0AA, 1'b0, 1'b0);
    queue_op(hsc_pkg::FUNC_ENCODE, 12'hF00, 1'b0, 1'b0);
    // Decode: clean word, single flips on check and data bits, all-zero and all-one words
    queue_op(hsc_pkg::FUNC_DECODE, cw, 1'b1, 1'b0);
    queue_op(hsc_pkg::FUNC_DECODE, cw ^ 12'h001, 1'b0, 1'b0);
    queue_op(hsc_pkg::FUNC_DECODE, cw ^ 12'h002, 1'b0, 1'b0);
    queue_op(hsc_pkg::FUNC_DECODE, cw ^ 12'h004, 1'b0, 1'b0);
    queue_op(hsc_pkg::FUNC_DECODE, cw ^ 12'h008, 1'b0, 1'b0);
    queue_op(hsc_pkg::FUNC_DECODE, cw ^ 12'h080, 1'b0, 1'b0);
    queue_op(hsc_pkg::FUNC_DECODE, cw ^ 12'h800, 1'b0, 1'b0);
    queue_op(hsc_pkg::FUNC_DECODE, 12'h000, 1'b0, 1'b0);
    queue_op(hsc_pkg::FUNC_DECODE, 12'hFFF, 1'b0, 1'b0);
    // Double flips that push the syndrome past the codeword (13, 14, 15)
    queue_op(hsc_pkg::FUNC_DECODE, cw ^ 12'h801, 1'b0, 1'b0);
    queue_op(hsc_pkg::FUNC_DECODE, cw ^ 12'h802, 1'b0, 1'b0);
    queue_op(hsc_pkg::FUNC_DECODE, cw ^ 12'h804, 1'b0, 1'b0);

    for (int k = 0; k < N_RANDOM; k++) begin
      // alternate idle / no-idle stretches, none in the tail
      idle = (k < 520) && ((k / 100) % 2 == 0);
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
        queue_op(hsc_pkg::FUNC_ENCODE, IN_W'($urandom), k == 300, idle);
      end else if (kind <= 8) begin
        cw = hamming_encode(IN_W'($urandom));
        case ($urandom_range(0, 3))
          0: ;
          1, 2: cw[$urandom_range(0, CW_LEN - 1)] ^= 1'b1;
          default: begin
            p0 = $urandom_range(0, CW_LEN - 1);
            cw[p0] ^= 1'b1;
            cw[(p0 + $urandom_range(1, CW_LEN - 1)) % CW_LEN] ^= 1'b1;
          end
        endcase
        queue_op(hsc_pkg::FUNC_DECODE, cw, k == 300, idle);
      end else begin
        queue_op(hsc_pkg::FUNC_DECODE, IN_W'($urandom), k == 300, idle);
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (op_q.size() != 0 || start || rsp_exp_q.size() != 0) @(negedge clk_i);
    repeat (FLUSH_CYC) @(posedge clk_i);
    if (!failed) begin
      $display("[hamming_sec_codec] OK");
    end else begin
      $display("[hamming_sec_codec] ERROR");
    end
    $finish;
  end

endmodule

// ----- hamming_sec_codec.f -----
src/hsc_pkg.sv
src/hsc_prep.sv
src/hsc_syn.sv
src/hsc_fix.sv
src/hamming_sec_codec.sv
src/hsc_checker.sv
dv/hamming_sec_codec_tb.sv
